>>> hw/rtl/i4h_pkg.sv
// ----------------------------------------------------------------------------
// i4h_pkg
// Types and constants shared by the indexed 4-ary min-heap and its testbench.
// ----------------------------------------------------------------------------
package i4h_pkg;

    localparam int NODE_W     = 10;
    localparam int KEY_W      = 32;
    localparam int NODE_COUNT = 1 << NODE_W;

    localparam logic [1:0] OP_INIT    = 2'd0;
    localparam logic [1:0] OP_DEC_KEY = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [NODE_W-1:0] node;
        logic [KEY_W-1:0]  key;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0] min_node;
        logic              found;
    } t_res;

    // one heap slot
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [KEY_W-1:0]  key;
    } t_entry;

endpackage

>>> hw/rtl/i4h_ram.sv
// ----------------------------------------------------------------------------
// i4h_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i4h_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hw/rtl/indexed_4ary_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_4ary_min_heap
// Indexed 4-ary min-heap of node ids keyed by 24.8 distance, with a table
// from node id to heap slot; one heap RAM port walks the sift loops.
// ----------------------------------------------------------------------------
// channel   direction  handshake                      payload
// command   in         start & !busy                  i_cmd (op, node, key)
// result    out        o_res_valid, one-cycle strobe  o_res (min_node, found)
// config    in         i_cfg_valid & o_cfg_ready      i_cfg_data (infinity_key)
//
// Steps to result: init writes the root; decrease_key reads the position table,
// checks the slot, then climbs a level per parent read and compare; extract
// answers when empty or from the root for the last entry, else reads the last
// entry, then per level reads and compares up to four children, then writes.
// Reset runs a pass clearing the position table; busy is high.
// The result strobe cannot be stalled; a new command may start in its cycle.
// ----------------------------------------------------------------------------
module indexed_4ary_min_heap #(
    parameter int CAPACITY = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  i4h_pkg::t_cmd             i_cmd,
    output logic                      o_res_valid,
    output i4h_pkg::t_res             o_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [i4h_pkg::KEY_W-1:0] i_cfg_data
);

    localparam int PW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CHW = PW + 3;
    localparam int NW  = i4h_pkg::NODE_W;
    localparam int KW  = i4h_pkg::KEY_W;
    localparam int EW  = NW + KW;

    localparam logic [3:0] ST_CLR     = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_DK_POS  = 4'd2;
    localparam logic [3:0] ST_DK_VER  = 4'd3;
    localparam logic [3:0] ST_UP      = 4'd4;
    localparam logic [3:0] ST_UP_CMP  = 4'd5;
    localparam logic [3:0] ST_EX_ROOT = 4'd6;
    localparam logic [3:0] ST_EX_LAST = 4'd7;
    localparam logic [3:0] ST_DN_RD   = 4'd8;
    localparam logic [3:0] ST_DN_CMP  = 4'd9;
    localparam logic [3:0] ST_DN_END  = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [PW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_best, n_best;
    logic [NW-1:0] r_best_node, n_best_node;
    logic [KW-1:0] r_best_key, n_best_key;
    logic [NW-1:0] r_node, n_node;
    logic [KW-1:0] r_key, n_key;
    logic [NW-1:0] r_min, n_min;
    logic [1:0]    r_op, n_op;
    logic [1:0]    r_j, n_j;
    logic [CW-1:0] r_count, n_count;
    logic [NW-1:0] r_clr, n_clr;
    logic [KW-1:0] r_inf;
    logic          r_res_valid, n_res_valid;
    i4h_pkg::t_res r_res, n_res;

    logic            heap_we;
    logic [PW-1:0]   heap_waddr, heap_raddr;
    i4h_pkg::t_entry heap_wdata, heap_rdata;
    logic [EW-1:0]   heap_rbits;
    logic            pos_we;
    logic [NW-1:0]   pos_waddr, pos_raddr;
    logic [PW-1:0]   pos_wdata, pos_rdata;

    logic [CHW-1:0]  child;
    logic [PW-1:0]   parent;

    assign heap_rdata = i4h_pkg::t_entry'(heap_rbits);
    assign child  = ({3'b000, r_cur} << 2) + CHW'(r_j) + CHW'(1);
    assign parent = (r_cur - PW'(1)) >> 2;

    i4h_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rbits)
    );

    i4h_ram #(.WIDTH(PW), .DEPTH(i4h_pkg::NODE_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_best      = r_best;
        n_best_node = r_best_node;
        n_best_key  = r_best_key;
        n_node      = r_node;
        n_key       = r_key;
        n_min       = r_min;
        n_op        = r_op;
        n_j         = r_j;
        n_count     = r_count;
        n_clr       = r_clr;
        n_res_valid = 1'b0;
        n_res       = '0;
        heap_we     = 1'b0;
        heap_waddr  = r_cur;
        heap_wdata  = '{node: r_node, key: r_key};
        heap_raddr  = r_cur;
        pos_we      = 1'b0;
        pos_waddr   = r_node;
        pos_wdata   = r_cur;
        pos_raddr   = r_node;

        case (r_state)
            ST_CLR: begin
                pos_we    = 1'b1;
                pos_waddr = r_clr;
                pos_wdata = '0;
                n_clr     = r_clr + NW'(1);
                if (r_clr == {NW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_op   = i_cmd.op;
                    n_node = i_cmd.node;
                    n_key  = i_cmd.key;
                    case (i_cmd.op)
                        i4h_pkg::OP_INIT: begin
                            heap_we     = 1'b1;
                            heap_waddr  = '0;
                            heap_wdata  = '{node: i_cmd.node, key: i_cmd.key};
                            pos_we      = 1'b1;
                            pos_waddr   = i_cmd.node;
                            pos_wdata   = '0;
                            n_count     = CW'(1);
                            n_res_valid = 1'b1;
                        end
                        i4h_pkg::OP_DEC_KEY: begin
                            pos_raddr = i_cmd.node;
                            n_state   = ST_DK_POS;
                        end
                        i4h_pkg::OP_EXTRACT: begin
                            heap_raddr = '0;
                            if (r_count == '0) begin
                                n_res_valid = 1'b1;
                            end else begin
                                n_state = ST_EX_ROOT;
                            end
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_DK_POS: begin
                // a node is present when its slot is live and holds it
                heap_raddr = pos_rdata;
                n_cur      = pos_rdata;
                if (CW'(pos_rdata) < r_count) begin
                    n_state = ST_DK_VER;
                end else if (r_count >= CW'(CAPACITY)) begin
                    n_state     = ST_IDLE;
                    n_res_valid = 1'b1;
                end else begin
                    n_cur   = PW'(r_count);
                    n_count = r_count + CW'(1);
                    n_state = ST_UP;
                end
            end
            ST_DK_VER: begin
                if (heap_rdata.node == r_node) begin
                    n_state = ST_UP;
                end else if (r_count >= CW'(CAPACITY)) begin
                    n_state     = ST_IDLE;
                    n_res_valid = 1'b1;
                end else begin
                    n_cur   = PW'(r_count);
                    n_count = r_count + CW'(1);
                    n_state = ST_UP;
                end
            end
            ST_UP: begin
                heap_raddr = parent;
                n_best     = parent;
                if (r_cur == '0) begin
                    heap_we     = 1'b1;
                    pos_we      = 1'b1;
                    n_state     = ST_IDLE;
                    n_res_valid = 1'b1;
                end else begin
                    n_state = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (heap_rdata.key > r_key) begin
                    // parent moves down into the hole
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = heap_rdata.node;
                    n_cur      = r_best;
                    n_state    = ST_UP;
                end else begin
                    heap_we     = 1'b1;
                    pos_we      = 1'b1;
                    n_state     = ST_IDLE;
                    n_res_valid = 1'b1;
                end
            end
            ST_EX_ROOT: begin
                n_min      = heap_rdata.node;
                heap_raddr = PW'(r_count - CW'(1));
                if (r_count == CW'(1)) begin
                    heap_we      = 1'b1;
                    heap_waddr   = '0;
                    heap_wdata   = '{node: '0, key: r_inf};
                    n_count      = '0;
                    n_state      = ST_IDLE;
                    n_res_valid  = 1'b1;
                    n_res.min_node = heap_rdata.node;
                    n_res.found    = 1'b1;
                end else begin
                    n_state = ST_EX_LAST;
                end
            end
            ST_EX_LAST: begin
                n_node     = heap_rdata.node;
                n_key      = heap_rdata.key;
                n_best_key = heap_rdata.key;
                n_count    = r_count - CW'(1);
                n_cur      = '0;
                n_best     = '0;
                n_j        = '0;
                n_state    = ST_DN_RD;
            end
            ST_DN_RD: begin
                heap_raddr = child[PW-1:0];
                if (child < CHW'(r_count)) begin
                    n_state = ST_DN_CMP;
                end else begin
                    n_state = ST_DN_END;
                end
            end
            ST_DN_CMP: begin
                // first strictly smaller child wins
                if (heap_rdata.key < r_best_key) begin
                    n_best      = child[PW-1:0];
                    n_best_key  = heap_rdata.key;
                    n_best_node = heap_rdata.node;
                end
                n_j = r_j + 2'd1;
                if (r_j == 2'd3) begin
                    n_state = ST_DN_END;
                end else begin
                    n_state = ST_DN_RD;
                end
            end
            ST_DN_END: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (r_best == r_cur) begin
                    n_state        = ST_IDLE;
                    n_res_valid    = 1'b1;
                    n_res.min_node = r_min;
                    n_res.found    = 1'b1;
                end else begin
                    heap_wdata = '{node: r_best_node, key: r_best_key};
                    pos_waddr  = r_best_node;
                    n_cur      = r_best;
                    n_best_key = r_key;
                    n_j        = '0;
                    n_state    = ST_DN_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_count     <= '0;
            r_inf       <= {KW{1'b1}};
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid) begin
                r_inf <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_best      <= n_best;
        r_best_node <= n_best_node;
        r_best_key  <= n_best_key;
        r_node      <= n_node;
        r_key       <= n_key;
        r_min       <= n_min;
        r_op        <= n_op;
        r_j         <= n_j;
        r_res       <= n_res;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("heap count above capacity");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result strobe while busy");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !start) |-> !heap_we && !pos_we)
        else $error("RAM written while idle");

    a_found_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.found) |-> o_res.min_node == '0)
        else $error("node reported without found");

    a_found_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.found) |-> r_op == i4h_pkg::OP_EXTRACT)
        else $error("found flagged for non-extract");
`endif

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for indexed_4ary_min_heap: a shadow heap predicts every result
// strobe of init, decrease_key, extract_min and the unused opcode. Directed
// edge cases run first, then random command streams with random idle gaps.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HEAP_SLOTS  = 1024;
    localparam int CYCLE_LIMIT = 1000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    i4h_pkg::t_cmd i_cmd = '0;
    logic        o_res_valid;
    i4h_pkg::t_res o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [i4h_pkg::KEY_W-1:0] i_cfg_data = '0;

    indexed_4ary_min_heap #(.CAPACITY(HEAP_SLOTS)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // shadow heap
    logic [i4h_pkg::KEY_W-1:0]  inf_key;
    bit                         node_in_heap [i4h_pkg::NODE_COUNT];
    int unsigned                slot_of_node [i4h_pkg::NODE_COUNT];
    logic [i4h_pkg::NODE_W-1:0] slot_node    [HEAP_SLOTS];
    logic [i4h_pkg::KEY_W-1:0]  slot_key     [HEAP_SLOTS];
    int unsigned                heap_size;

    i4h_pkg::t_res pending_res[$];
    int          mismatches = 0;
    int unsigned cycles = 0;
    bit          idle_off = 0;
    int          node_span = 15;
    bit          narrow_keys = 0;

    function automatic void clear_heap();
        for (int i = 0; i < i4h_pkg::NODE_COUNT; i++) begin
            node_in_heap[i] = 0;
            slot_of_node[i] = 0;
        end
        for (int i = 0; i < HEAP_SLOTS; i++) begin
            slot_node[i] = '0;
            slot_key[i]  = inf_key;
        end
        heap_size = 0;
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [i4h_pkg::NODE_W-1:0] na, nb;
        logic [i4h_pkg::KEY_W-1:0]  tk;
        na = slot_node[a];
        nb = slot_node[b];
        slot_of_node[na] = b;
        slot_of_node[nb] = a;
        slot_node[a] = nb;
        slot_node[b] = na;
        tk = slot_key[a];
        slot_key[a] = slot_key[b];
        slot_key[b] = tk;
    endfunction

    function automatic void sift_up(int unsigned s);
        int unsigned p;
        while (s > 0) begin
            p = (s - 1) / 4;
            if (!(slot_key[p] > slot_key[s])) return;
            swap_slots(s, p);
            s = p;
        end
    endfunction

    function automatic void sift_down(int unsigned s);
        int unsigned best;
        logic [i4h_pkg::KEY_W-1:0] best_key;
        forever begin
            best = s;
            best_key = slot_key[s];
            // first strictly smaller child wins ties
            for (int unsigned c = 4 * s + 1; c <= 4 * s + 4; c++) begin
                if (c < heap_size && slot_key[c] < best_key) begin
                    best = c;
                    best_key = slot_key[c];
                end
            end
            if (best == s) return;
            swap_slots(s, best);
            s = best;
        end
    endfunction

    function automatic i4h_pkg::t_res heap_apply(i4h_pkg::t_cmd c);
        i4h_pkg::t_res r;
        logic [i4h_pkg::NODE_W-1:0] m;
        r = '0;
        case (c.op)
            i4h_pkg::OP_INIT: begin
                clear_heap();
                slot_key[0] = c.key;
                slot_node[0] = c.node;
                node_in_heap[c.node] = 1;
                slot_of_node[c.node] = 0;
                heap_size = 1;
            end
            i4h_pkg::OP_DEC_KEY: begin
                if (!node_in_heap[c.node]) begin
                    if (heap_size >= HEAP_SLOTS) return r;
                    slot_node[heap_size] = c.node;
                    slot_key[heap_size] = inf_key;
                    node_in_heap[c.node] = 1;
                    slot_of_node[c.node] = heap_size;
                    heap_size++;
                end
                if (slot_of_node[c.node] < heap_size) begin
                    slot_key[slot_of_node[c.node]] = c.key;
                    sift_up(slot_of_node[c.node]);
                end
            end
            i4h_pkg::OP_EXTRACT: begin
                if (heap_size == 0) return r;
                m = slot_node[0];
                if (heap_size > 1) begin
                    swap_slots(0, heap_size - 1);
                    heap_size--;
                    sift_down(0);
                end else begin
                    heap_size = 0;
                    slot_node[0] = '0;
                    slot_key[0] = inf_key;
                end
                node_in_heap[m] = 0;
                slot_of_node[m] = 0;
                r.min_node = m;
                r.found = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one command transfer; start stays high across back-to-back commands
    task automatic send_cmd(logic [1:0] op, logic [i4h_pkg::NODE_W-1:0] node,
                            logic [i4h_pkg::KEY_W-1:0] key);
        int gap;
        i4h_pkg::t_cmd c;
        gap = pick_gap();
        c.op = op;
        c.node = node;
        c.key = key;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_res.push_back(heap_apply(c));
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_inf_key(logic [i4h_pkg::KEY_W-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        inf_key = v;
    endtask

    task automatic test_empty_and_unused();
        send_cmd(i4h_pkg::OP_EXTRACT, '0, '0);
        send_cmd(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
        send_cmd(i4h_pkg::OP_DEC_KEY, 10'd5, 32'd100);
        send_cmd(i4h_pkg::OP_EXTRACT, '0, '0);
        send_cmd(i4h_pkg::OP_EXTRACT, '0, '0);
    endtask

    task automatic test_extremes();
        send_cmd(i4h_pkg::OP_INIT, 10'h3FF, 32'hFFFF_FFFF);
        send_cmd(i4h_pkg::OP_DEC_KEY, 10'd0, 32'd0);
        send_cmd(i4h_pkg::OP_DEC_KEY, 10'h2AA, 32'hAAAA_AAAA);
        send_cmd(i4h_pkg::OP_DEC_KEY, 10'h155, 32'h5555_5555);
        send_cmd(i4h_pkg::OP_EXTRACT, '0, '0);
        send_cmd(i4h_pkg::OP_INIT, 10'd0, 32'd0);
    endtask

    // equal keys do not swap; a raised key stays in place
    task automatic test_ties_and_raise();
        send_cmd(i4h_pkg::OP_INIT, 10'd7, 32'd50);
        for (int n = 1; n <= 6; n++) send_cmd(i4h_pkg::OP_DEC_KEY, n[9:0], 32'd50);
        send_cmd(i4h_pkg::OP_DEC_KEY, 10'd7, 32'd900);
        send_cmd(i4h_pkg::OP_DEC_KEY, 10'd3, 32'd10);
        for (int n = 0; n < 8; n++) send_cmd(i4h_pkg::OP_EXTRACT, '0, '0);
    endtask

    task automatic test_random(int count);
        int r;
        logic [i4h_pkg::KEY_W-1:0] k;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                idle_off = ($urandom_range(0, 3) == 0);
                node_span = ($urandom_range(0, 2) == 0) ? 1023 : $urandom_range(3, 60);
                narrow_keys = $urandom_range(0, 1);
            end
            r = $urandom_range(0, 99);
            k = narrow_keys ? 32'($urandom_range(0, 31)) : 32'($urandom);
            if (r < 3)
                send_cmd(i4h_pkg::OP_INIT, 10'($urandom_range(0, node_span)), k);
            else if (r < 5)
                send_cmd(OP_UNUSED, 10'($urandom), 32'($urandom));
            else if (r < 60)
                send_cmd(i4h_pkg::OP_DEC_KEY, 10'($urandom_range(0, node_span)), k);
            else
                send_cmd(i4h_pkg::OP_EXTRACT, 10'($urandom), 32'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        i4h_pkg::t_res want;
        if (i_rst_n && o_res_valid) begin
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: min_node=%0d found=%0b",
                             o_res.min_node, o_res.found);
            end else begin
                want = pending_res.pop_front();
                if (o_res.min_node !== want.min_node || o_res.found !== want.found) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp min_node=%0d found=%0b, got %0d %0b",
                                 want.min_node, want.found, o_res.min_node, o_res.found);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("indexed_4ary_min_heap verification failed");
            $finish;
        end
    end

    initial begin
        inf_key = 32'hFFFF_FFFF;
        clear_heap();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_unused();
        test_extremes();
        write_inf_key(32'h0000_0000);
        test_ties_and_raise();
        test_random(500);
        write_inf_key(32'h8000_0100);
        test_random(600);
        write_inf_key(32'hFFFF_FFFF);
        test_random(600);
        settle();
        if (mismatches == 0)
            $display("indexed_4ary_min_heap verification clean");
        else
            $display("indexed_4ary_min_heap verification failed");
        $finish;
    end

endmodule
